/* sv/cafd_pkg.sv */
`timescale 1ns / 1ps
package cafd_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_BOARD_ADDRESS     = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_FORMAT     = 3'd1;
   localparam logic [2:0] CSR_CALIBRATION_MODE  = 3'd2;
   localparam logic [2:0] CSR_FULL_SCALE_FIRST  = 3'd3;
   localparam logic [2:0] CSR_FULL_SCALE_SECOND = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT_TICKS     = 3'd5;

   localparam int unsigned CSR_DATA_W = 48;

   // sample formats
   localparam logic [1:0] FMT_BYTE = 2'd0;
   localparam logic [1:0] FMT_WORD = 2'd1;

   // sensor status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OVF     = 2'd1;
   localparam logic [1:0] ST_ERR     = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   // identifier fields
   localparam logic [2:0] IDENT_CLASS = 3'd3;
   localparam logic [3:0] GRP_A = 4'hA;
   localparam logic [3:0] GRP_B = 4'hB;
   localparam logic [3:0] GRP_C = 4'hC;
   localparam logic [3:0] GRP_D = 4'hD;

   localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
   localparam logic [0:0]  CMD_FRAME   = 1'b0;
   localparam logic [7:0]  OVF_MARKER  = 8'h01;
   localparam logic [3:0]  LEN_OK      = 4'd6;
   localparam logic [3:0]  LEN_OVF     = 4'd7;

   typedef struct packed {
      logic       cmd;
      logic [10:0] frame_ident;
      logic [3:0] frame_length;
      logic [7:0] payload_b0;
      logic [7:0] payload_b1;
      logic [7:0] payload_b2;
      logic [7:0] payload_b3;
      logic [7:0] payload_b4;
      logic [7:0] payload_b5;
      logic [7:0] payload_b6;
      logic [7:0] payload_b7;
   } req_type;

   typedef struct packed {
      logic              channel_updated;
      logic [3:0]        channel_index;
      logic signed [31:0] channel_value;
      logic [1:0]        sensor_status;
      logic              bad_group;
      logic              last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_BYTE = 2'd1,
      KIND_WORD = 2'd2
   } kind_type;

   // one decoded frame or tick, ready to be split into result words
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  last_idx;
      logic [3:0]  base_index;
      logic [63:0] payload;     // byte 0 in the low bits
      logic [47:0] factor;      // channel factor 0 in the low bits
      logic        calib;
      logic [1:0]  status;
      logic        bad;
   } run_type;

   typedef struct packed {
      logic [3:0]  board_address;
      logic [1:0]  sample_format;
      logic [1:0]  calibration_mode;
      logic [47:0] full_scale_first;
      logic [47:0] full_scale_second;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

/* sv/cafd_decode.sv */
`timescale 1ns / 1ps
module cafd_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  cafd_pkg::req_type req,
   input  cafd_pkg::cfg_type cfg,
   output cafd_pkg::run_type run
);
   import cafd_pkg::*;

   logic [1:0]  frame_status_ff, frame_status_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        match;
   logic [3:0]  grp;

   assign grp   = req.frame_ident[3:0];
   assign match = (req.frame_ident[10:8] == IDENT_CLASS) &&
                  (req.frame_ident[7:4] == cfg.board_address);

   always_comb begin
      frame_status_in = frame_status_ff;
      ticks_in        = ticks_ff;
      run.kind        = KIND_NONE;
      run.last_idx    = 3'd0;
      run.base_index  = 4'd0;
      run.payload     = {req.payload_b7, req.payload_b6, req.payload_b5, req.payload_b4,
                         req.payload_b3, req.payload_b2, req.payload_b1, req.payload_b0};
      run.factor      = cfg.full_scale_first;
      run.calib       = (cfg.calibration_mode != 2'd0);
      run.bad         = 1'b0;
      if (req.cmd != CMD_FRAME[0]) begin
         if (ticks_ff != TICKS_MAX) begin
            ticks_in = ticks_ff + 16'd1;
         end
      end else begin
         frame_status_in = ST_OK;
         if (match) begin
            ticks_in = 16'd0;
            case (cfg.sample_format)
               FMT_BYTE: begin
                  if (grp == GRP_C) begin
                     run.kind     = KIND_BYTE;
                     run.last_idx = 3'd6;
                  end else if (grp == GRP_D) begin
                     run.kind       = KIND_BYTE;
                     run.last_idx   = 3'd7;
                     run.base_index = 4'd7;
                  end else if (grp != GRP_A && grp != GRP_B) begin
                     run.bad = 1'b1;
                  end
               end
               FMT_WORD: begin
                  if (req.frame_length == LEN_OK) begin
                     frame_status_in = ST_OK;
                  end else if (req.frame_length == LEN_OVF &&
                               req.payload_b6 == OVF_MARKER) begin
                     frame_status_in = ST_OVF;
                  end else begin
                     frame_status_in = ST_ERR;
                  end
                  if (grp == GRP_A) begin
                     run.kind     = KIND_WORD;
                     run.last_idx = 3'd2;
                  end else if (grp == GRP_B) begin
                     run.kind       = KIND_WORD;
                     run.last_idx   = 3'd2;
                     run.base_index = 4'd3;
                     run.factor     = cfg.full_scale_second;
                  end else if (grp != GRP_C && grp != GRP_D) begin
                     run.bad = 1'b1;
                  end
               end
               default: begin
                  frame_status_in = ST_ERR;
               end
            endcase
         end
      end
      run.status = (ticks_in > cfg.timeout_ticks) ? ST_TIMEOUT : frame_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_status_ff <= ST_OK;
         ticks_ff        <= TICKS_MAX;
      end else if (accept) begin
         frame_status_ff <= frame_status_in;
         ticks_ff        <= ticks_in;
      end
   end

endmodule

/* sv/cafd_emit.sv */
`timescale 1ns / 1ps
module cafd_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cafd_pkg::run_type run_in,
   output logic             run_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cafd_pkg::rsp_type rsp_data
);
   import cafd_pkg::*;

   run_type     run_ff;
   logic        run_valid_ff;
   logic [2:0]  k_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic        out_free, emit, run_done;
   logic [15:0] word_sel, factor_sel;
   logic signed [15:0] raw;
   logic signed [32:0] prod;
   logic [7:0]  byte_sel;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = run_valid_ff && out_free;
   assign run_done = emit && (k_ff == run_ff.last_idx);
   assign run_free = !run_valid_ff || run_done;

   assign byte_sel = run_ff.payload[{k_ff, 3'b000} +: 8];

   always_comb begin
      case (k_ff[1:0])
         2'd0: begin
            word_sel   = run_ff.payload[15:0];
            factor_sel = run_ff.factor[15:0];
         end
         2'd1: begin
            word_sel   = run_ff.payload[31:16];
            factor_sel = run_ff.factor[31:16];
         end
         2'd2: begin
            word_sel   = run_ff.payload[47:32];
            factor_sel = run_ff.factor[47:32];
         end
         default: begin
            word_sel   = 16'd0;
            factor_sel = 16'd0;
         end
      endcase
   end

   // offset binary to two's complement: flip the top bit
   assign raw  = {~word_sel[15], word_sel[14:0]};
   assign prod = raw * $signed({1'b0, factor_sel});

   always_comb begin
      rsp_in.channel_updated = 1'b1;
      rsp_in.channel_index   = run_ff.base_index + {1'b0, k_ff};
      rsp_in.sensor_status   = run_ff.status;
      rsp_in.bad_group       = run_ff.bad;
      rsp_in.last_of_run     = (k_ff == run_ff.last_idx);
      case (run_ff.kind)
         KIND_BYTE: rsp_in.channel_value = {9'd0, byte_sel, 15'd0};
         KIND_WORD: begin
            if (run_ff.calib) begin
               rsp_in.channel_value = prod[31:0];
            end else begin
               rsp_in.channel_value = {raw[15], raw, 15'd0};
            end
         end
         default: begin
            rsp_in.channel_updated = 1'b0;
            rsp_in.channel_index   = 4'd0;
            rsp_in.channel_value   = 32'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         k_ff         <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            run_valid_ff <= 1'b1;
            k_ff         <= 3'd0;
         end else if (run_done) begin
            run_valid_ff <= 1'b0;
         end else if (emit) begin
            k_ff <= k_ff + 3'd1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/can_analog_frame_decoder.sv */
`timescale 1ns / 1ps
// Request words are registered in the run register, result words in the output register.
// A tick or a frame without channel data gives one result word; a data frame sends one
// channel word per cycle unless the output stalls (3 for 16-bit groups, 7 or 8 for 8-bit
// groups), and the next request is taken in the cycle its last word leaves.
// Reset (synchronous): registers to defaults, status ok, tick age saturated.
module can_analog_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cafd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cafd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [cafd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cafd_pkg::*;

   cfg_type cfg_ff;
   run_type run;
   logic    run_free;
   logic    accept;

   assign req_stall = !run_free;
   assign accept    = req_valid && run_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_address     <= 4'd0;
         cfg_ff.sample_format     <= FMT_WORD;
         cfg_ff.calibration_mode  <= 2'd0;
         cfg_ff.full_scale_first  <= 48'd0;
         cfg_ff.full_scale_second <= 48'd0;
         cfg_ff.timeout_ticks     <= 16'd100;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOARD_ADDRESS:     cfg_ff.board_address     <= csr_wdata[3:0];
            CSR_SAMPLE_FORMAT:     cfg_ff.sample_format     <= csr_wdata[1:0];
            CSR_CALIBRATION_MODE:  cfg_ff.calibration_mode  <= csr_wdata[1:0];
            CSR_FULL_SCALE_FIRST:  cfg_ff.full_scale_first  <= csr_wdata[47:0];
            CSR_FULL_SCALE_SECOND: cfg_ff.full_scale_second <= csr_wdata[47:0];
            CSR_TIMEOUT_TICKS:     cfg_ff.timeout_ticks     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   cafd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .run    (run)
   );

   cafd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .run_in    (run),
      .run_free  (run_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a word that does not close its run always carries a channel value
   a_mid_run_updates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> rsp_data.channel_updated)
      else $error("mid-run word without channel value");

   // words without a channel value carry zero index and value
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.channel_updated |->
         rsp_data.channel_index == 4'd0 && rsp_data.channel_value == 32'sd0)
      else $error("empty word carries channel data");

   // a bad group never comes with channel data
   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_group |-> !rsp_data.channel_updated)
      else $error("bad group with channel data");

endmodule

/* bench/cafd_monitor.sv */
`timescale 1ns / 1ps
module cafd_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  cafd_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  cafd_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [cafd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              words_waiting
);
   import cafd_pkg::*;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   cfg_type     regs;
   logic [1:0]  status_held;
   logic [15:0] tick_age;
   rsp_type     expected_words[$];
   int          fail_count = 0;

   assign mismatches = fail_count;

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t: result word %h arrived with nothing expected", $time, got);
      end else begin
         want = expected_words.pop_front();
         compare_field("channel_updated", 32'(want.channel_updated), 32'(got.channel_updated));
         compare_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
         compare_field("channel_value", want.channel_value, got.channel_value);
         compare_field("sensor_status", 32'(want.sensor_status), 32'(got.sensor_status));
         compare_field("bad_group", 32'(want.bad_group), 32'(got.bad_group));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      end
   endtask

   // work out the result words one request word causes and queue them
   task automatic decode_word(input req_type w);
      logic [63:0] bytes;
      logic [3:0]  grp;
      logic [3:0]  base;
      logic [47:0] scale;
      logic [3:0]  chan [8];
      logic [31:0] value [8];
      longint      raw;
      longint      prod;
      int          count;
      int          n;
      logic        bad;
      logic [1:0]  status;
      rsp_type     r;
      n = 0;
      bad = 1'b0;
      bytes = {w.payload_b7, w.payload_b6, w.payload_b5, w.payload_b4,
               w.payload_b3, w.payload_b2, w.payload_b1, w.payload_b0};
      if (w.cmd != CMD_FRAME[0]) begin
         if (tick_age != TICKS_MAX) tick_age++;
      end else begin
         status_held = ST_OK;
         if (w.frame_ident[10:8] == IDENT_CLASS && w.frame_ident[7:4] == regs.board_address) begin
            grp = w.frame_ident[3:0];
            tick_age = '0;
            if (regs.sample_format == FMT_BYTE) begin
               if (grp == GRP_C || grp == GRP_D) begin
                  base = (grp == GRP_C) ? 4'd0 : 4'd7;
                  count = (grp == GRP_C) ? 7 : 8;
                  for (int k = 0; k < count; k++) begin
                     chan[n] = base + 4'(k);
                     prod = longint'(bytes[8*k +: 8]) * 32768;
                     value[n] = prod[31:0];
                     n++;
                  end
               end else if (grp != GRP_A && grp != GRP_B) begin
                  bad = 1'b1;
               end
            end else if (regs.sample_format == FMT_WORD) begin
               if (w.frame_length == LEN_OK)
                  status_held = ST_OK;
               else if (w.frame_length == LEN_OVF && w.payload_b6 == OVF_MARKER)
                  status_held = ST_OVF;
               else
                  status_held = ST_ERR;
               if (grp == GRP_A || grp == GRP_B) begin
                  base = (grp == GRP_A) ? 4'd0 : 4'd3;
                  scale = (grp == GRP_A) ? regs.full_scale_first : regs.full_scale_second;
                  for (int k = 0; k < 3; k++) begin
                     // offset binary, low byte first
                     raw = longint'(bytes[16*k +: 16]) - 32768;
                     if (regs.calibration_mode != 2'd0)
                        prod = raw * longint'(scale[16*k +: 16]);
                     else
                        prod = raw * 32768;
                     chan[n] = base + 4'(k);
                     value[n] = prod[31:0];
                     n++;
                  end
               end else if (grp != GRP_C && grp != GRP_D) begin
                  bad = 1'b1;
               end
            end else begin
               status_held = ST_ERR;
            end
         end
      end

      status = (tick_age > regs.timeout_ticks) ? ST_TIMEOUT : status_held;

      if (n == 0) begin
         r = '0;
         r.sensor_status = status;
         r.bad_group = bad;
         r.last_of_run = 1'b1;
         expected_words.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.channel_updated = 1'b1;
            r.channel_index = chan[k];
            r.channel_value = value[k];
            r.sensor_status = status;
            r.bad_group = bad;
            r.last_of_run = (k == n - 1);
            expected_words.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.board_address = '0;
         regs.sample_format = FMT_WORD;
         regs.calibration_mode = '0;
         regs.full_scale_first = '0;
         regs.full_scale_second = '0;
         regs.timeout_ticks = TIMEOUT_RESET;
         status_held = ST_OK;
         tick_age = TICKS_MAX;
         expected_words.delete();
         words_waiting <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BOARD_ADDRESS:     regs.board_address = csr_wdata[3:0];
               CSR_SAMPLE_FORMAT:     regs.sample_format = csr_wdata[1:0];
               CSR_CALIBRATION_MODE:  regs.calibration_mode = csr_wdata[1:0];
               CSR_FULL_SCALE_FIRST:  regs.full_scale_first = csr_wdata[47:0];
               CSR_FULL_SCALE_SECOND: regs.full_scale_second = csr_wdata[47:0];
               CSR_TIMEOUT_TICKS:     regs.timeout_ticks = csr_wdata[15:0];
               default: ;
            endcase
         end
         // a word leaving now belongs to an earlier request, so check before queuing
         if (rsp_valid && !rsp_stall) check_word(rsp_data);
         if (req_valid && !req_stall) decode_word(req_data);
         words_waiting <= expected_words.size();
      end
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import cafd_pkg::*;

   localparam logic       CMD_TICK       = 1'b1;
   localparam logic [1:0] FMT_BAD        = 2'd2;
   localparam logic [1:0] FMT_BAD_HIGH   = 2'd3;
   localparam logic [3:0] GRP_NONE       = 4'h0;
   localparam logic [3:0] GRP_TOP        = 4'hF;
   localparam int         IDLE_PERCENT   = 31;
   localparam int         HOLD_CYCLES    = 80;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         RANDOM_PHASES  = 6;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic    quiet = 1'b0;
   logic    hold_go = 1'b0;
   bit      hold_taken = 1'b0;
   cfg_type settings;
   int      mismatches;
   int      words_waiting;

   can_analog_frame_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cafd_monitor i_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .words_waiting (words_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin : watchdog
      int dry_cycles;
      dry_cycles = 0;
      while (dry_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            dry_cycles = 0;
         else
            dry_cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   function automatic cfg_type make_settings(input logic [3:0] addr, input logic [1:0] fmt,
                                             input logic [1:0] cal, input logic [47:0] fs1,
                                             input logic [47:0] fs2, input logic [15:0] tmo);
      cfg_type c;
      c.board_address = addr;
      c.sample_format = fmt;
      c.calibration_mode = cal;
      c.full_scale_first = fs1;
      c.full_scale_second = fs2;
      c.timeout_ticks = tmo;
      return c;
   endfunction

   function automatic cfg_type random_settings(input int p);
      cfg_type c;
      c.board_address = 4'($urandom_range(15));
      if (p == 4)
         c.sample_format = 2'($urandom_range(2, 3));
      else
         c.sample_format = (p % 2 == 1) ? FMT_WORD : FMT_BYTE;
      c.calibration_mode = 2'($urandom_range(3));
      c.full_scale_first = 48'({$urandom, $urandom});
      c.full_scale_second = 48'({$urandom, $urandom});
      case ($urandom_range(3))
         0: c.timeout_ticks = 16'($urandom_range(6));
         1: c.timeout_ticks = TICKS_MAX;
         2: c.timeout_ticks = TICKS_MAX - 16'd1;
         default: c.timeout_ticks = 16'($urandom);
      endcase
      return c;
   endfunction

   function automatic req_type with_payload(input req_type w, input logic [63:0] bytes);
      w.payload_b0 = bytes[7:0];
      w.payload_b1 = bytes[15:8];
      w.payload_b2 = bytes[23:16];
      w.payload_b3 = bytes[31:24];
      w.payload_b4 = bytes[39:32];
      w.payload_b5 = bytes[47:40];
      w.payload_b6 = bytes[55:48];
      w.payload_b7 = bytes[63:56];
      return w;
   endfunction

   function automatic req_type frame_word(input logic [3:0] grp, input logic [3:0] len,
                                          input logic [63:0] bytes);
      req_type w;
      w = '0;
      w.cmd = CMD_FRAME[0];
      w.frame_ident = {IDENT_CLASS, settings.board_address, grp};
      w.frame_length = len;
      return with_payload(w, bytes);
   endfunction

   function automatic req_type tick_word();
      logic [95:0] noise;
      req_type     w;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(req_type)-1:0];
      w.cmd = CMD_TICK;
      return w;
   endfunction

   // mostly well-formed frames for this board, the rest ticks and noise
   function automatic req_type random_word();
      logic [95:0] noise;
      req_type     w;
      int          pick;
      logic [3:0]  grp;
      logic        native_byte;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      native_byte = (settings.sample_format == FMT_BYTE);
      if (pick < 12) begin
         w.cmd = CMD_TICK;
      end else begin
         w.cmd = CMD_FRAME[0];
         if (pick < 88) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: begin
                  if (native_byte) grp = ($urandom_range(1) == 0) ? GRP_C : GRP_D;
                  else grp = ($urandom_range(1) == 0) ? GRP_A : GRP_B;
               end
               6, 7: begin
                  if (native_byte) grp = ($urandom_range(1) == 0) ? GRP_A : GRP_B;
                  else grp = ($urandom_range(1) == 0) ? GRP_C : GRP_D;
               end
               default: grp = 4'($urandom_range(15));
            endcase
            w.frame_ident = {IDENT_CLASS, settings.board_address, grp};
            case ($urandom_range(9))
               0, 1, 2, 3, 4: w.frame_length = LEN_OK;
               5, 6, 7: begin
                  w.frame_length = LEN_OVF;
                  if ($urandom_range(2) != 0) w.payload_b6 = OVF_MARKER;
               end
               default: ;
            endcase
         end
         case ($urandom_range(9))
            0: w = with_payload(w, '0);
            1: w = with_payload(w, '1);
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // hold the sender until every queued result word has left
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      put_reg(CSR_BOARD_ADDRESS, CSR_DATA_W'(c.board_address));
      put_reg(CSR_SAMPLE_FORMAT, CSR_DATA_W'(c.sample_format));
      put_reg(CSR_CALIBRATION_MODE, CSR_DATA_W'(c.calibration_mode));
      put_reg(CSR_FULL_SCALE_FIRST, CSR_DATA_W'(c.full_scale_first));
      put_reg(CSR_FULL_SCALE_SECOND, CSR_DATA_W'(c.full_scale_second));
      put_reg(CSR_TIMEOUT_TICKS, CSR_DATA_W'(c.timeout_ticks));
      csr_we <= 1'b0;
      settings = c;
   endtask

   initial begin : stimulus
      req_type w;
      int      count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sixteen-bit raw data, highest address, timeout of one tick
      write_settings(make_settings('1, FMT_WORD, 2'd0, '0, '0, 16'd1));
      send_word(tick_word());
      send_word(frame_word(GRP_A, LEN_OK, '0));
      send_word(frame_word(GRP_A, LEN_OK, '1));
      send_word(frame_word(GRP_B, LEN_OVF, 64'h0001_0000_FFFF_8000));
      send_word(frame_word(GRP_A, LEN_OVF, 64'h0002_1234_5678_9ABC));
      send_word(frame_word(GRP_B, 4'd8, {$urandom, $urandom}));
      send_word(frame_word(GRP_B, 4'd0, {$urandom, $urandom}));
      send_word(frame_word(GRP_C, LEN_OK, {$urandom, $urandom}));
      send_word(frame_word(GRP_NONE, LEN_OK, {$urandom, $urandom}));
      send_word(frame_word(GRP_TOP, 4'hF, {$urandom, $urandom}));
      w = frame_word(GRP_A, LEN_OK, {$urandom, $urandom});
      w.frame_ident[10:8] = ~IDENT_CLASS;
      send_word(w);
      w = frame_word(GRP_A, LEN_OK, {$urandom, $urandom});
      w.frame_ident[7:4] = ~settings.board_address;
      send_word(w);
      // two ticks push the age past a limit of one
      send_word(tick_word());
      send_word(tick_word());
      drain_results();

      // full calibration at the factor extremes
      write_settings(make_settings('0, FMT_WORD, 2'd3, '1, 48'h0000_8000_0001,
                                   TICKS_MAX - 16'd1));
      send_word(frame_word(GRP_A, LEN_OK, '0));
      send_word(frame_word(GRP_A, LEN_OK, '1));
      send_word(frame_word(GRP_B, LEN_OK, {$urandom, $urandom}));
      drain_results();

      // eight-bit channels, timeout disabled
      write_settings(make_settings(4'd5, FMT_BYTE, 2'd1, 48'({$urandom, $urandom}),
                                   48'({$urandom, $urandom}), TICKS_MAX));
      send_word(frame_word(GRP_C, 4'hF, '1));
      send_word(frame_word(GRP_D, 4'd0, 64'h8001_7F00_FF80_0102));
      send_word(frame_word(GRP_A, LEN_OK, {$urandom, $urandom}));
      send_word(frame_word(GRP_TOP, LEN_OK, {$urandom, $urandom}));
      send_word(tick_word());
      drain_results();

      // invalid formats
      write_settings(make_settings(4'd10, FMT_BAD, 2'd0, '0, '0, 16'd100));
      send_word(frame_word(GRP_A, LEN_OK, {$urandom, $urandom}));
      w = frame_word(GRP_A, LEN_OK, {$urandom, $urandom});
      w.frame_ident[10:8] = ~IDENT_CLASS;
      send_word(w);
      drain_results();
      write_settings(make_settings(4'd10, FMT_BAD_HIGH, 2'd2, '1, '1, 16'd100));
      send_word(frame_word(GRP_C, LEN_OK, {$urandom, $urandom}));
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet <= (p == 1 || p == 2);
         hold_go <= (p == 2);
         write_settings(random_settings(p));
         count = (p == 4) ? 30 : 94;
         for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_results();
            send_word(random_word());
         end
         drain_results();
      end

      if (mismatches == 0 && words_waiting == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

/* files.f */
sv/cafd_pkg.sv
sv/cafd_decode.sv
sv/cafd_emit.sv
sv/can_analog_frame_decoder.sv
bench/cafd_monitor.sv
bench/testbench.sv
